>>> rtl/bbfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfs_pkg
// shared types, request codes and widths for the bit and byte field serializer
// ----------------------------------------------------------------------------
package bbfs_pkg;

  localparam int REQ_W   = 3;
  localparam int VALUE_W = 64;
  localparam int SIZE_W  = 7;
  localparam int BYTE_W  = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_BITS  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_U30   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_HALF  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_INT64 = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step_bits;
    logic merge_bits;
    logic step_buf;
    logic sel_bits;
  } bbfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bits_full;
    logic buf_nonempty;
  } bbfs_sts_t;

endpackage
`default_nettype wire

>>> rtl/bbfs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfs_in_if
// request channel: valid/ready handshake with request type, value and size
// ----------------------------------------------------------------------------
interface bbfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [bbfs_pkg::REQ_W-1:0]    req_type;
  logic [bbfs_pkg::VALUE_W-1:0]  value;
  logic [bbfs_pkg::SIZE_W-1:0]   size_count;

  modport source (output valid, output req_type, output value, output size_count,
                  input ready);
  modport sink (input valid, input req_type, input value, input size_count,
                output ready);
endinterface
`default_nettype wire

>>> rtl/bbfs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfs_out_if
// byte stream channel: valid/ready handshake with byte and last flag
// ----------------------------------------------------------------------------
interface bbfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [bbfs_pkg::BYTE_W-1:0]  out_byte;
  logic                         last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/bit_and_byte_field_serializer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// the first byte of a request is valid the cycle after the request beat
// a request emits b bytes (0..9), one byte a beat; no new request is taken until it is done
// besides its bytes a request takes a datapath load and a final merge or empty check
// unused request types are dropped at acceptance; an int64 goes out word-swapped
// reset: synchronous active-low rst_n clears the partial byte, fill count and sequencer
// ----------------------------------------------------------------------------
// bit_and_byte_field_serializer_top
// packs msb-first bit fields and byte fields (le int, varint, half, int64)
// into a byte stream, one beat per byte with last on each request's final byte
// ----------------------------------------------------------------------------
module bit_and_byte_field_serializer_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bbfs_in_if.sink    in_ch,
  bbfs_out_if.source out_ch
);
  import bbfs_pkg::*;

  bbfs_cmd_t cmd;
  bbfs_sts_t sts;

  // sequencer: one request in flight, steps bytes on output beats
  bbfs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath: partial byte state, bit shifter and byte buffer
  bbfs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_ch.req_type),
    .in_value      (in_ch.value),
    .in_size_count (in_ch.size_count),
    .cmd           (cmd),
    .sts           (sts),
    .out_byte      (out_ch.out_byte),
    .out_last      (out_ch.last)
  );

  // a request is never taken while a byte is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("request accepted while a byte is pending");

  // after the last byte of a request nothing else is offered for it
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid)
    else $error("byte offered after last");

  // a known request drops ready in the cycle after it is accepted
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.req_type <= REQ_INT64) |=> !in_ch.ready)
    else $error("ready right after a known request");

  // unused request types are dropped at once
  a_unused_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.req_type > REQ_INT64) |=> in_ch.ready && !out_ch.valid)
    else $error("unused request type not dropped");

endmodule
`default_nettype wire

>>> rtl/bbfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfs_ctrl
// request sequencer: accepts a request, then steps the datapath one byte a beat
// ----------------------------------------------------------------------------
module bbfs_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [bbfs_pkg::REQ_W-1:0]  in_req_type,
  output logic                             in_ready,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  input  wire bbfs_pkg::bbfs_sts_t         sts,
  output bbfs_pkg::bbfs_cmd_t              cmd
);
  import bbfs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BITS = 2'd1;
  localparam logic [1:0] S_BUF  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_req_type == REQ_BITS) begin
            state_nxt = S_BITS;
          end else if (in_req_type inside {[REQ_FLUSH:REQ_INT64]}) begin
            state_nxt = S_BUF;
          end
        end
      end
      S_BITS: begin
        cmd.sel_bits = 1'b1;
        if (sts.bits_full) begin
          out_valid      = 1'b1;
          cmd.step_bits  = out_ready;
        end else begin
          // leftover bits fold into the partial byte
          cmd.merge_bits = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_BUF: begin
        if (sts.buf_nonempty) begin
          out_valid    = 1'b1;
          cmd.step_buf = out_ready;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bbfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfs_dp
// datapath: partial byte, msb-first bit shifter and byte buffer for fields
// ----------------------------------------------------------------------------
module bbfs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bbfs_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [bbfs_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [bbfs_pkg::SIZE_W-1:0]   in_size_count,
  input  wire bbfs_pkg::bbfs_cmd_t           cmd,
  output bbfs_pkg::bbfs_sts_t                sts,
  output logic [bbfs_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last
);
  import bbfs_pkg::*;

  // float32 to half, truncating, denormal inputs to zero
  function automatic logic [15:0] f32_to_half(input logic [31:0] f);
    logic [7:0]  ex;
    logic [22:0] man;
    logic [4:0]  hex;
    logic [9:0]  hman;
    logic [4:0]  sh;
    logic [23:0] shifted;
    ex      = f[30:23];
    man     = f[22:0];
    sh      = 5'(8'd126 - ex);
    shifted = {1'b1, man} >> sh;
    if (ex == 8'h00) begin
      hex  = 5'h00;
      hman = 10'h000;
    end else if (ex == 8'hFF) begin
      hex  = 5'h1F;
      hman = {9'h000, |man};
    end else if (ex < 8'd113) begin
      hex  = 5'h00;
      hman = (ex >= 8'd103) ? shifted[9:0] : 10'h000;
    end else if (ex > 8'd142) begin
      hex  = 5'h1F;
      hman = 10'h000;
    end else begin
      hex  = 5'(ex - 8'd112);
      hman = man[22:13];
    end
    return {f[31], hex, hman};
  endfunction

  logic [BYTE_W-1:0]   partial_r, partial_nxt;
  logic [2:0]          fill_r, fill_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;
  logic [71:0]         buf_r, buf_nxt;
  logic [3:0]          cnt_r, cnt_nxt;

  logic [3:0]          k;
  logic [7:0]          avail;
  logic [BYTE_W-1:0]   bits_byte;
  logic [SIZE_W-1:0]   n_bits;
  logic [63:0]         body;
  logic [3:0]          body_cnt;
  logic [2:0]          nb;
  logic [31:0]         w;
  logic [2:0]          vlen;
  logic                has_partial;

  assign k         = 4'd8 - {1'b0, fill_r};
  assign avail     = 8'(fill_r) + 8'(rem_r);
  assign bits_byte = partial_r | (acc_r[63:56] >> fill_r);
  assign has_partial = (fill_r != 3'd0);
  assign w         = in_value[31:0];
  assign n_bits    = (in_size_count > 7'd64) ? 7'd64 : in_size_count;

  assign sts.bits_full    = (avail >= 8'd8);
  assign sts.buf_nonempty = (cnt_r != 4'd0);

  assign out_byte = cmd.sel_bits ? bits_byte : buf_r[7:0];
  assign out_last = cmd.sel_bits ? (avail < 8'd16) : (cnt_r == 4'd1);

  // bytes of a byte-oriented field, first out in the low byte
  always_comb begin
    body     = '0;
    body_cnt = 4'd0;
    if (in_size_count == 7'd0) begin
      nb = 3'd1;
    end else if (in_size_count > 7'd4) begin
      nb = 3'd4;
    end else begin
      nb = in_size_count[2:0];
    end
    vlen = 3'd1 + 3'(w >= 32'h80) + 3'(w >= 32'h4000) + 3'(w >= 32'h20_0000)
         + 3'(w >= 32'h1000_0000);
    case (in_req_type)
      REQ_INT: begin
        body     = {32'h0, w};
        body_cnt = {1'b0, nb};
      end
      REQ_U30: begin
        body     = {24'h0, 4'h0, w[31:28], vlen > 3'd4, w[27:21], vlen > 3'd3, w[20:14],
                    vlen > 3'd2, w[13:7], vlen > 3'd1, w[6:0]};
        body_cnt = {1'b0, vlen};
      end
      REQ_HALF: begin
        body     = {48'h0, f32_to_half(w)};
        body_cnt = 4'd2;
      end
      REQ_INT64: begin
        body     = {in_value[31:0], in_value[63:32]};
        body_cnt = 4'd8;
      end
      default: begin
        body     = '0;
        body_cnt = 4'd0;
      end
    endcase
  end

  always_comb begin
    partial_nxt = partial_r;
    fill_nxt    = fill_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    if (cmd.load) begin
      if (in_req_type == REQ_BITS) begin
        // left-align the masked value
        acc_nxt = in_value << (7'd64 - n_bits);
        rem_nxt = n_bits;
      end else if (in_req_type inside {[REQ_FLUSH:REQ_INT64]}) begin
        // pending partial byte goes out first
        buf_nxt     = has_partial ? {body, partial_r} : {8'h00, body};
        cnt_nxt     = body_cnt + 4'(has_partial);
        partial_nxt = '0;
        fill_nxt    = 3'd0;
      end
    end else if (cmd.step_bits) begin
      acc_nxt     = acc_r << k;
      rem_nxt     = rem_r - 7'(k);
      partial_nxt = '0;
      fill_nxt    = 3'd0;
    end else if (cmd.merge_bits) begin
      partial_nxt = bits_byte;
      fill_nxt    = fill_r + rem_r[2:0];
      rem_nxt     = '0;
    end else if (cmd.step_buf) begin
      buf_nxt = {8'h00, buf_r[71:8]};
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= 3'd0;
      rem_r     <= '0;
      cnt_r     <= 4'd0;
    end else begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
      rem_r     <= rem_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire
